[sv/hlpg_pkg.sv]
package hlpg_pkg;

    localparam int PIXEL_COUNT_DEF = 5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam int PCT_MAX = 100;

    localparam logic [2:0] MODE_RST     = 3'd0;
    localparam logic [8:0] HUE_LOW_RST  = 9'd0;
    localparam logic [8:0] HUE_HIGH_RST = 9'd359;
    localparam logic [6:0] SAT_LOW_RST  = 7'd0;
    localparam logic [6:0] SAT_HIGH_RST = 7'd99;
    localparam logic [6:0] VAL_LOW_RST  = 7'd0;
    localparam logic [6:0] VAL_HIGH_RST = 7'd24;

    // reciprocal constants, exact floor over the whole numerator range
    localparam int          HUE_SH     = 16;
    localparam int unsigned HUE_RECIP  = 1093;
    localparam int          SH_100     = 22;
    localparam int unsigned RECIP_100  = ((32'd1 << SH_100) + 32'd99) / 32'd100;
    localparam int          SH_10K     = 36;
    localparam longint unsigned RECIP_10K =
        ((64'd1 << SH_10K) + 64'd9999) / 64'd10000;
    localparam int          SH_600K    = 48;
    localparam longint unsigned RECIP_600K =
        ((64'd1 << SH_600K) + 64'd599999) / 64'd600000;

    typedef enum logic [2:0] {
        CFG_PATTERN_MODE = 3'd0,
        CFG_HUE_LOW      = 3'd1,
        CFG_HUE_HIGH     = 3'd2,
        CFG_SAT_LOW      = 3'd3,
        CFG_SAT_HIGH     = 3'd4,
        CFG_VAL_LOW      = 3'd5,
        CFG_VAL_HIGH     = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        MODE_WALK_END   = 3'd0,
        MODE_WALK_START = 3'd1,
        MODE_MIDDLE_OUT = 3'd2,
        MODE_ENDS_IN    = 3'd3,
        MODE_RANDOM     = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SECTOR,
        ST_FRAC,
        ST_PROD,
        ST_SCALE,
        ST_COLOR,
        ST_OUT0,
        ST_OUT1
    } t_state;

    typedef struct packed {
        logic [4:0] hue_step;
        logic [2:0] sat_step;
        logic [2:0] val_step;
        logic [2:0] random_pixel;
    } t_in_item;

    typedef struct packed {
        logic [2:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_write;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic sel;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] count;
    } t_dp_stat;

endpackage

[sv/hlpg_ctrl.sv]
module hlpg_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  hlpg_pkg::t_dp_stat  i_stat,
    output hlpg_pkg::t_dp_cmd   o_cmd
);

    hlpg_pkg::t_state r_state;
    hlpg_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hlpg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd.load  = 1'b0;
        o_cmd.sel   = 1'b0;
        case (r_state)
            hlpg_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = hlpg_pkg::ST_SECTOR;
                end
            end
            hlpg_pkg::ST_SECTOR: n_state = hlpg_pkg::ST_FRAC;
            hlpg_pkg::ST_FRAC:   n_state = hlpg_pkg::ST_PROD;
            hlpg_pkg::ST_PROD:   n_state = hlpg_pkg::ST_SCALE;
            hlpg_pkg::ST_SCALE:  n_state = hlpg_pkg::ST_COLOR;
            hlpg_pkg::ST_COLOR: begin
                n_state = (i_stat.count == 2'd0) ? hlpg_pkg::ST_IDLE : hlpg_pkg::ST_OUT0;
            end
            hlpg_pkg::ST_OUT0: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = (i_stat.count == 2'd2) ? hlpg_pkg::ST_OUT1 : hlpg_pkg::ST_IDLE;
                end
            end
            hlpg_pkg::ST_OUT1: begin
                o_out_valid = 1'b1;
                o_cmd.sel   = 1'b1;
                if (i_out_ready) begin
                    n_state = hlpg_pkg::ST_IDLE;
                end
            end
            default: n_state = hlpg_pkg::ST_IDLE;
        endcase
    end

endmodule

[sv/hlpg_datapath.sv]
module hlpg_datapath #(
    parameter int PIXEL_COUNT = hlpg_pkg::PIXEL_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [hlpg_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [hlpg_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  hlpg_pkg::t_in_item                  i_item,
    input  hlpg_pkg::t_dp_cmd                   i_cmd,
    output hlpg_pkg::t_dp_stat                  o_stat,
    output hlpg_pkg::t_out_item                 o_item
);

    localparam int WALK_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int POS_W  = $clog2(PIXEL_COUNT + 1);
    localparam int CAND_W = (POS_W > 3) ? POS_W : 3;
    localparam int MID    = PIXEL_COUNT / 2 + 1;

    // configuration
    logic [2:0] r_mode;
    logic [8:0] r_hue_low, r_hue_high;
    logic [6:0] r_sat_low, r_sat_high, r_val_low, r_val_high;

    // kept channels and walk
    logic [8:0]        r_hue;
    logic [6:0]        r_sat, r_val;
    logic [WALK_W-1:0] r_walk;

    // pixel writes of the current tick
    logic [1:0] r_count;
    logic [2:0] r_idx0, r_idx1;

    // conversion stages
    logic [3:0]  r_sector;
    logic [14:0] r_nv;
    logic [6:0]  r_sc;
    logic [5:0]  r_fr;
    logic [21:0] r_np;
    logic [7:0]  r_cv;
    logic [12:0] r_sf, r_sg;
    logic [7:0]  r_cp;
    logic [27:0] r_nq, r_nt;
    logic [7:0]  r_red, r_green, r_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= hlpg_pkg::MODE_RST;
            r_hue_low  <= hlpg_pkg::HUE_LOW_RST;
            r_hue_high <= hlpg_pkg::HUE_HIGH_RST;
            r_sat_low  <= hlpg_pkg::SAT_LOW_RST;
            r_sat_high <= hlpg_pkg::SAT_HIGH_RST;
            r_val_low  <= hlpg_pkg::VAL_LOW_RST;
            r_val_high <= hlpg_pkg::VAL_HIGH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hlpg_pkg::CFG_PATTERN_MODE: r_mode     <= i_cfg_data[2:0];
                hlpg_pkg::CFG_HUE_LOW:      r_hue_low  <= i_cfg_data[8:0];
                hlpg_pkg::CFG_HUE_HIGH:     r_hue_high <= i_cfg_data[8:0];
                hlpg_pkg::CFG_SAT_LOW:      r_sat_low  <= i_cfg_data[6:0];
                hlpg_pkg::CFG_SAT_HIGH:     r_sat_high <= i_cfg_data[6:0];
                hlpg_pkg::CFG_VAL_LOW:      r_val_low  <= i_cfg_data[6:0];
                hlpg_pkg::CFG_VAL_HIGH:     r_val_high <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // channel update with wrap and clamp
    logic [9:0]  w_hue_sum;
    logic [10:0] w_hue_wrap;
    logic [7:0]  w_sat_sum, w_val_sum;
    logic [8:0]  w_sat_wrap, w_val_wrap;
    logic [6:0]  n_hue_sat, n_val;
    logic [8:0]  n_hue;
    logic [6:0]  n_sat;

    always_comb begin
        w_hue_sum  = 10'(r_hue) + 10'(i_item.hue_step);
        w_hue_wrap = (w_hue_sum > 10'(r_hue_high))
                   ? 11'(w_hue_sum) - 11'(r_hue_high) + 11'(r_hue_low)
                   : 11'(w_hue_sum);
        n_hue      = w_hue_wrap[8:0];

        w_sat_sum  = 8'(r_sat) + 8'(i_item.sat_step);
        w_sat_wrap = (w_sat_sum > 8'(r_sat_high))
                   ? 9'(w_sat_sum) - 9'(r_sat_high) + 9'(r_sat_low)
                   : 9'(w_sat_sum);
        n_sat      = (w_sat_wrap > 9'(hlpg_pkg::PCT_MAX)) ? 7'(hlpg_pkg::PCT_MAX)
                                                         : w_sat_wrap[6:0];

        w_val_sum  = 8'(r_val) + 8'(i_item.val_step);
        w_val_wrap = (w_val_sum > 8'(r_val_high))
                   ? 9'(w_val_sum) - 9'(r_val_high) + 9'(r_val_low)
                   : 9'(w_val_sum);
        n_val      = (w_val_wrap > 9'(hlpg_pkg::PCT_MAX)) ? 7'(hlpg_pkg::PCT_MAX)
                                                         : w_val_wrap[6:0];
        n_hue_sat  = n_sat;
    end

    // pattern selection
    logic [POS_W-1:0]  w_limit, w_inc;
    logic [WALK_W-1:0] w_i, n_walk;
    logic [CAND_W-1:0] w_wi, w_c0, w_c1, w_idx0;
    logic              w_two, w_v0, w_v1;
    logic [1:0]        n_count;

    always_comb begin
        w_limit = ((r_mode == hlpg_pkg::MODE_WALK_END) || (r_mode == hlpg_pkg::MODE_WALK_START))
                ? POS_W'(PIXEL_COUNT) : POS_W'(MID);
        w_i     = (POS_W'(r_walk) < w_limit) ? r_walk : '0;
        w_inc   = POS_W'(w_i) + POS_W'(1);
        n_walk  = (w_inc >= w_limit) ? '0 : w_inc[WALK_W-1:0];
        w_wi    = CAND_W'(w_i);
        w_two   = 1'b0;
        w_c0    = w_wi;
        w_c1    = w_wi;
        case (r_mode)
            hlpg_pkg::MODE_WALK_END: begin
                w_c0 = CAND_W'(PIXEL_COUNT - 1) - w_wi;
            end
            hlpg_pkg::MODE_WALK_START: begin
                w_c0 = w_wi;
            end
            hlpg_pkg::MODE_MIDDLE_OUT: begin
                w_two = 1'b1;
                w_c0  = CAND_W'(MID - 1) + w_wi;
                w_c1  = CAND_W'(MID - 1) - w_wi;
            end
            hlpg_pkg::MODE_ENDS_IN: begin
                w_two = 1'b1;
                w_c0  = w_wi;
                w_c1  = CAND_W'(PIXEL_COUNT - 1) - w_wi;
            end
            default: begin
                w_c0   = CAND_W'(i_item.random_pixel);
                n_walk = '0;
            end
        endcase
        w_v0    = (w_c0 < CAND_W'(PIXEL_COUNT));
        w_v1    = w_two && (w_c1 < CAND_W'(PIXEL_COUNT)) && !(w_v0 && (w_c1 == w_c0));
        w_idx0  = w_v0 ? w_c0 : w_c1;
        n_count = 2'(w_v0) + 2'(w_v1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue  <= '0;
            r_sat  <= '0;
            r_val  <= '0;
            r_walk <= '0;
        end else if (i_cmd.load) begin
            r_hue  <= n_hue;
            r_sat  <= n_hue_sat;
            r_val  <= n_val;
            r_walk <= n_walk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_count <= n_count;
            r_idx0  <= w_idx0[2:0];
            r_idx1  <= w_c1[2:0];
        end
    end

    // hsv to rgb, one multiplier level per stage
    logic [19:0] w_hq;
    logic [5:0]  w_fr;
    logic [5:0]  w_fr_inv;
    logic [30:0] w_cv_prod;
    logic [44:0] w_cp_prod;
    logic [56:0] w_cq_prod, w_ct_prod;
    logic [7:0]  w_cq, w_ct;

    always_comb begin
        w_hq      = 20'(r_hue) * 20'(hlpg_pkg::HUE_RECIP);
        w_fr      = 6'(10'(r_hue) - 10'(r_sector) * 10'd60);
        w_fr_inv  = 6'd60 - r_fr;
        w_cv_prod = 31'(r_nv) * 31'(hlpg_pkg::RECIP_100);
        w_cp_prod = 45'(r_np) * 45'(hlpg_pkg::RECIP_10K);
        w_cq_prod = 57'(r_nq) * 57'(hlpg_pkg::RECIP_600K);
        w_ct_prod = 57'(r_nt) * 57'(hlpg_pkg::RECIP_600K);
        w_cq      = w_cq_prod[hlpg_pkg::SH_600K +: 8];
        w_ct      = w_ct_prod[hlpg_pkg::SH_600K +: 8];
    end

    always_ff @(posedge i_clk) begin
        // sector, 255 v and 100 - s
        r_sector <= w_hq[hlpg_pkg::HUE_SH +: 4];
        r_nv     <= 15'(r_val) * 15'd255;
        r_sc     <= 7'(hlpg_pkg::PCT_MAX) - r_sat;
        // fraction, p numerator, v component
        r_fr     <= w_fr;
        r_np     <= 22'(r_nv) * 22'(r_sc);
        r_cv     <= w_cv_prod[hlpg_pkg::SH_100 +: 8];
        // saturation products, p component
        r_sf     <= 13'(r_sat) * 13'(r_fr);
        r_sg     <= 13'(r_sat) * 13'(w_fr_inv);
        r_cp     <= w_cp_prod[hlpg_pkg::SH_10K +: 8];
        // q and t numerators
        r_nq     <= 28'(r_nv) * 28'(13'd6000 - r_sf);
        r_nt     <= 28'(r_nv) * 28'(13'd6000 - r_sg);
        // sector select
        case (r_sector)
            4'd0: begin
                r_red <= r_cv; r_green <= w_ct; r_blue <= r_cp;
            end
            4'd1: begin
                r_red <= w_cq; r_green <= r_cv; r_blue <= r_cp;
            end
            4'd2: begin
                r_red <= r_cp; r_green <= r_cv; r_blue <= w_ct;
            end
            4'd3: begin
                r_red <= r_cp; r_green <= w_cq; r_blue <= r_cv;
            end
            4'd4: begin
                r_red <= w_ct; r_green <= r_cp; r_blue <= r_cv;
            end
            default: begin
                r_red <= r_cv; r_green <= r_cp; r_blue <= w_cq;
            end
        endcase
    end

    assign o_stat.count      = r_count;
    assign o_item.pixel_index = i_cmd.sel ? r_idx1 : r_idx0;
    assign o_item.red        = r_red;
    assign o_item.green      = r_green;
    assign o_item.blue       = r_blue;
    assign o_item.last_write = i_cmd.sel | (r_count == 2'd1);

endmodule

[sv/hsv_led_pattern_generator.sv]
// Takes one animation tick per input beat, steps the kept hue, saturation and
// value, converts them to RGB and emits zero, one or two pixel writes for the
// selected pattern. One tick is in flight at a time: the input is taken in the
// idle cycle, the color conversion then runs through the sector, fraction,
// product, scale and color states of its chain of constant-reciprocal
// multipliers, and each pixel write is one output beat that holds while the
// output is stalled. The next tick is taken after the last beat.
module hsv_led_pattern_generator #(
    parameter int PIXEL_COUNT = hlpg_pkg::PIXEL_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hlpg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hlpg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  hlpg_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output hlpg_pkg::t_out_item             o_out_data
);

    hlpg_pkg::t_dp_cmd  w_cmd;
    hlpg_pkg::t_dp_stat w_stat;

    hlpg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    hlpg_datapath #(
        .PIXEL_COUNT (PIXEL_COUNT)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_in_data),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_item     (o_out_data)
    );

endmodule

[sv/hlpg_checker.sv]
module hlpg_checker #(
    parameter int PIXEL_COUNT = hlpg_pkg::PIXEL_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_ready,
    input  logic                o_out_valid,
    input  logic                i_out_ready,
    input  hlpg_pkg::t_out_item o_out_data
);

    // output beat holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed while stalled");

    // never taking a tick while a write is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while output beat pending");

    // a taken tick blocks the input until done
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready && !o_out_valid)
        else $error("input ready right after a taken tick");

    // a non-final write is followed by the second write
    a_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_data.last_write |=> o_out_valid)
        else $error("second write missing");

    // written pixel lies on the strip
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (PIXEL_COUNT > 7) || (32'(o_out_data.pixel_index) < PIXEL_COUNT))
        else $error("pixel index out of range");

endmodule

bind hsv_led_pattern_generator hlpg_checker #(
    .PIXEL_COUNT (PIXEL_COUNT)
) u_hlpg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

[verif/hsv_tick_scoreboard_pkg.sv]
`timescale 1ns / 1ps

package hsv_tick_scoreboard_pkg;
    import hlpg_pkg::*;

    localparam int unsigned PIXELS = PIXEL_COUNT_DEF;

    class hsv_tick_scoreboard;
        t_out_item   write_q[$];
        int unsigned errors;

        logic [2:0] mode;
        logic [8:0] hue_floor, hue_ceil, hue_now;
        logic [6:0] sat_floor, sat_ceil, sat_now;
        logic [6:0] val_floor, val_ceil, val_now;
        int unsigned walk_pos;

        function new();
            mode      = MODE_RST;
            hue_floor = HUE_LOW_RST;
            hue_ceil  = HUE_HIGH_RST;
            sat_floor = SAT_LOW_RST;
            sat_ceil  = SAT_HIGH_RST;
            val_floor = VAL_LOW_RST;
            val_ceil  = VAL_HIGH_RST;
            hue_now   = '0;
            sat_now   = '0;
            val_now   = '0;
            walk_pos  = 0;
            errors    = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [8:0] data);
            case (idx)
                CFG_PATTERN_MODE: mode      = data[2:0];
                CFG_HUE_LOW:      hue_floor = data;
                CFG_HUE_HIGH:     hue_ceil  = data;
                CFG_SAT_LOW:      sat_floor = data[6:0];
                CFG_SAT_HIGH:     sat_ceil  = data[6:0];
                CFG_VAL_LOW:      val_floor = data[6:0];
                CFG_VAL_HIGH:     val_ceil  = data[6:0];
                default: ;
            endcase
        endfunction

        function int unsigned wrap_over(int unsigned x, int unsigned lo, int unsigned hi);
            return (x > hi) ? (x - hi + lo) : x;
        endfunction

        function int pending();
            return write_q.size();
        endfunction

        // steps the channels, converts to rgb and queues the pixel writes of one tick
        function void note_tick(t_in_item tick);
            int unsigned h, s, v, sector, fr, cv, cp, cq, ct, limit, pos, mid;
            logic [7:0]  red, green, blue;
            int unsigned cand[$];
            int unsigned pix[$];
            t_out_item   wr;

            mid = PIXELS / 2 + 1;
            h = wrap_over(hue_now + tick.hue_step, hue_floor, hue_ceil) & 511;
            s = wrap_over(sat_now + tick.sat_step, sat_floor, sat_ceil);
            if (s > PCT_MAX) s = PCT_MAX;
            v = wrap_over(val_now + tick.val_step, val_floor, val_ceil);
            if (v > PCT_MAX) v = PCT_MAX;
            hue_now = 9'(h);
            sat_now = 7'(s);
            val_now = 7'(v);

            sector = h / 60;
            fr     = h % 60;
            cv = 255 * v / 100;
            cp = 255 * v * (100 - s) / 10000;
            cq = 255 * v * (6000 - s * fr) / 600000;
            ct = 255 * v * (6000 - s * (60 - fr)) / 600000;
            case (sector)
                0: begin red = 8'(cv); green = 8'(ct); blue = 8'(cp); end
                1: begin red = 8'(cq); green = 8'(cv); blue = 8'(cp); end
                2: begin red = 8'(cp); green = 8'(cv); blue = 8'(ct); end
                3: begin red = 8'(cp); green = 8'(cq); blue = 8'(cv); end
                4: begin red = 8'(ct); green = 8'(cp); blue = 8'(cv); end
                default: begin red = 8'(cv); green = 8'(cp); blue = 8'(cq); end
            endcase

            if (mode <= MODE_ENDS_IN) begin
                limit = (mode <= MODE_WALK_START) ? PIXELS : mid;
                pos = (walk_pos < limit) ? walk_pos : 0;
                case (mode)
                    MODE_WALK_END:   cand.push_back(PIXELS - 1 - pos);
                    MODE_WALK_START: cand.push_back(pos);
                    MODE_MIDDLE_OUT: begin
                        cand.push_back(mid + pos - 1);
                        cand.push_back(mid - pos - 1);
                    end
                    default: begin
                        cand.push_back(pos);
                        cand.push_back(PIXELS - 1 - pos);
                    end
                endcase
                walk_pos = (pos + 1 >= limit) ? 0 : pos + 1;
            end else begin
                cand.push_back(tick.random_pixel);
                walk_pos = 0;
            end

            foreach (cand[j]) begin
                if (cand[j] >= PIXELS) continue;
                if (pix.size() == 1 && pix[0] == cand[j]) continue;
                pix.push_back(cand[j]);
            end

            foreach (pix[j]) begin
                wr.pixel_index = 3'(pix[j]);
                wr.red         = red;
                wr.green       = green;
                wr.blue        = blue;
                wr.last_write  = (j == pix.size() - 1);
                write_q.push_back(wr);
            end
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_write(t_out_item got);
            t_out_item want;
            if (write_q.size() == 0) begin
                $display("%0t: pixel write with none expected, expected none got %h",
                         $time, got);
                errors++;
                return;
            end
            want = write_q.pop_front();
            check_field("pixel_index", want.pixel_index, got.pixel_index);
            check_field("red",         want.red,         got.red);
            check_field("green",       want.green,       got.green);
            check_field("blue",        want.blue,        got.blue);
            check_field("last_write",  want.last_write,  got.last_write);
        endfunction
    endclass

endpackage

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
    import hlpg_pkg::*;
    import hsv_tick_scoreboard_pkg::*;

    localparam int          CYCLE_LIMIT   = 500000;
    localparam int          LONG_HOLD     = 300;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          PHASES        = 9;
    localparam int          PHASE_TICKS   = 150;
    localparam logic [2:0]  MODE_ALIAS_LO = 3'd5;
    localparam logic [2:0]  MODE_ALIAS_HI = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    t_in_item    in_data;
    logic        out_valid;
    logic        out_ready;
    t_out_item   out_data;

    hsv_tick_scoreboard sb;
    logic [8:0]  cfg_val [0:6];
    int          idle_odds;
    bit          calm;
    bit          hold_req;
    int          cycle_count = 0;

    hsv_led_pattern_generator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && in_ready) sb.note_tick(in_data);
            if (out_valid && out_ready) sb.check_write(out_data);
        end
    end

    // output side backpressure
    initial begin
        bit held;
        held = 1'b0;
        out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!calm && $urandom_range(3, 0) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(12, 1)) @(posedge i_clk);
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(20, 1)) @(posedge i_clk);
            end
        end
    end

    task automatic send_tick(input logic [4:0] h, input logic [2:0] s, v, p);
        t_in_item tick;
        tick.hue_step     = h;
        tick.sat_step     = s;
        tick.val_step     = v;
        tick.random_pixel = p;
        in_valid <= 1'b1;
        in_data  <= tick;
        do @(posedge i_clk); while (!in_ready);
        if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge i_clk);
        end
    endtask

    task automatic send_random_tick();
        send_tick(5'($urandom), 3'($urandom), 3'($urandom), 3'($urandom));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // a tick with no pixel write can still be in flight once the queue is empty
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_all_regs();
        for (int k = CFG_PATTERN_MODE; k <= CFG_VAL_HIGH; k++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= t_cfg_idx'(k);
            cfg_data <= cfg_val[k];
            sb.write_reg(t_cfg_idx'(k), cfg_val[k]);
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_cfg(input logic [2:0] mode, input logic [8:0] hl, hh,
                           input logic [6:0] sl, sh, vl, vh);
        cfg_val[CFG_PATTERN_MODE] = {6'd0, mode};
        cfg_val[CFG_HUE_LOW]      = hl;
        cfg_val[CFG_HUE_HIGH]     = hh;
        cfg_val[CFG_SAT_LOW]      = {2'd0, sl};
        cfg_val[CFG_SAT_HIGH]     = {2'd0, sh};
        cfg_val[CFG_VAL_LOW]      = {2'd0, vl};
        cfg_val[CFG_VAL_HIGH]     = {2'd0, vh};
        write_all_regs();
    endtask

    task automatic set_random_cfg();
        bit legal;
        legal = ($urandom_range(3, 0) != 0);
        if ($urandom_range(5, 0) == 0)
            cfg_val[CFG_PATTERN_MODE] = {6'd0, 3'($urandom_range(MODE_ALIAS_HI, MODE_ALIAS_LO))};
        else
            cfg_val[CFG_PATTERN_MODE] = {6'd0, 3'($urandom_range(MODE_RANDOM, MODE_WALK_END))};
        if (legal) begin
            cfg_val[CFG_HUE_LOW]  = 9'($urandom_range(359, 0));
            cfg_val[CFG_HUE_HIGH] = 9'($urandom_range(359, 0));
            cfg_val[CFG_SAT_LOW]  = 9'($urandom_range(PCT_MAX, 0));
            cfg_val[CFG_SAT_HIGH] = 9'($urandom_range(PCT_MAX, 0));
            cfg_val[CFG_VAL_LOW]  = 9'($urandom_range(PCT_MAX, 0));
            cfg_val[CFG_VAL_HIGH] = 9'($urandom_range(PCT_MAX, 0));
        end else begin
            // unused upper data bits carry junk
            cfg_val[CFG_PATTERN_MODE][8:3] = 6'($urandom);
            cfg_val[CFG_HUE_LOW]  = 9'($urandom);
            cfg_val[CFG_HUE_HIGH] = 9'($urandom);
            cfg_val[CFG_SAT_LOW]  = 9'($urandom);
            cfg_val[CFG_SAT_HIGH] = 9'($urandom);
            cfg_val[CFG_VAL_LOW]  = 9'($urandom);
            cfg_val[CFG_VAL_HIGH] = 9'($urandom);
        end
        write_all_regs();
    endtask

    initial begin
        sb          = new();
        idle_odds   = 0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        i_rst_n  <= 1'b0;
        cfg_we   <= 1'b0;
        cfg_idx  <= '0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, field extremes
        idle_odds = 3;
        send_tick(5'd0, 3'd0, 3'd0, 3'd0);
        send_tick(5'd31, 3'd7, 3'd7, 3'd7);
        send_tick(5'd19, 3'd4, 3'd4, 3'd4);
        send_tick(5'd21, 3'd5, 3'd2, 3'd5);

        // walk to the last pixel, then middle out sees an out of range position
        settle();
        set_cfg(MODE_WALK_START, 9'd0, 9'd359, 7'd0, 7'd100, 7'd0, 7'd100);
        repeat (4) send_tick(5'd31, 3'd7, 3'd7, 3'd0);
        settle();
        set_cfg(MODE_MIDDLE_OUT, 9'd0, 9'd359, 7'd0, 7'd100, 7'd0, 7'd100);
        repeat (3) send_tick(5'd29, 3'd6, 3'd1, 3'd0);
        settle();
        set_cfg(MODE_ENDS_IN, 9'd0, 9'd359, 7'd0, 7'd100, 7'd0, 7'd100);
        repeat (3) send_tick(5'd17, 3'd3, 3'd6, 3'd0);

        // hue past 360 and past 512, saturation and value clamped, all random pixels
        settle();
        set_cfg(MODE_RANDOM, 9'd500, 9'd0, 7'd127, 7'd0, 7'd127, 7'd0);
        for (int p = 0; p < 8; p++) send_tick(5'($urandom), 3'd1, 3'd1, 3'(p));
        settle();
        set_cfg(MODE_ALIAS_HI, 9'd0, 9'd511, 7'd0, 7'd127, 7'd0, 7'd127);
        send_tick(5'd31, 3'd7, 3'd7, 3'd2);
        send_tick(5'd31, 3'd7, 3'd7, 3'd6);

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0: set_cfg(MODE_WALK_END, 9'd0, 9'd0, 7'd0, 7'd0, 7'd0, 7'd0);
                1: set_cfg(MODE_RANDOM, 9'd359, 9'd359, 7'd100, 7'd100, 7'd100, 7'd100);
                2: set_cfg(MODE_ALIAS_HI, 9'd511, 9'd511, 7'd127, 7'd127, 7'd127, 7'd127);
                default: set_random_cfg();
            endcase
            case ($urandom_range(2, 0))
                0: idle_odds = 0;
                1: idle_odds = 8;
                default: idle_odds = 3;
            endcase
            if (ph == 3) hold_req = 1'b1;
            if (ph == PHASES - 1) begin
                calm      = 1'b1;
                idle_odds = 0;
            end
            for (int n = 0; n < PHASE_TICKS; n++) begin
                if (ph == 4 && n == PHASE_TICKS / 2) drain();
                send_random_tick();
            end
        end

        drain();
        repeat (SETTLE_CYCLES * 2) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            if (sb.pending() != 0)
                $display("%0t: %0d pixel writes expected, none arrived", $time, sb.pending());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
